>>> src/vgm_pkg.sv
// ---------------------------------------------------------------------------
// vgm_pkg
// Shared constants and helpers for the volume gradient magnitude core.
// ---------------------------------------------------------------------------
package vgm_pkg;

   localparam int MAX_ROW_LENGTH = 512;
   localparam int MAX_ROWS       = 512;

   localparam int SAMPLE_W    = 16;
   localparam int LEN_W       = 10;                          // geometry register width
   localparam int COL_W       = $clog2(MAX_ROW_LENGTH);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int SLICE_DEPTH = MAX_ROW_LENGTH * MAX_ROWS;
   localparam int SLICE_AW    = $clog2(SLICE_DEPTH);
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int SUM_W       = 35;
   localparam int ROOT_W      = (SUM_W + 1) / 2;
   localparam int REM_W       = ROOT_W + 3;
   localparam int STEP_W      = $clog2(ROOT_W);

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PER_SLICE = 1'b1;

   localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(512);

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                  input logic [LEN_W-1:0] hi);
      logic [LEN_W-1:0] r;
      r = v;
      if (v < LEN_MIN) r = LEN_MIN;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> src/vgm_sqrt.sv
// ---------------------------------------------------------------------------
// vgm_sqrt
// Restoring floor square root, one result bit per cycle. The result and
// done stay valid until the next start.
// ---------------------------------------------------------------------------
module vgm_sqrt
   import vgm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [2*ROOT_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      trial;

   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], rad_ff[2*ROOT_W-1 -: 2]};
      trial     = REM_W'({root_ff, 2'b01});
      busy_in   = busy_ff;
      done_in   = done_ff;
      step_in   = step_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rad_in  = (2*ROOT_W)'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*ROOT_W-3:0], 2'b00};
         step_in = step_ff + STEP_W'(1);
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> src/volume_gradient_magnitude_core.sv
// ---------------------------------------------------------------------------
// volume_gradient_magnitude_core
// Backward-difference 3D gradient and its magnitude over a raster voxel
// stream.
// ---------------------------------------------------------------------------
// One voxel is processed at a time. The row and slice stores are read at the
// transfer edge. After that come the differences and the write-back, the
// squares through a single 16x16 multiplier, the bit-serial square root, and
// the move of the result into the output register. The next voxel is taken
// in the following cycle, so the block takes no new voxel while one is in
// work. A finished result waits in the square root until the output
// register is free. Once it has moved there, the next voxel can be in work
// while that result waits. Both stores are single-port synchronous RAMs
// that are not cleared; entries are written on the first slice before they
// are used. The user must write the geometry registers only while no voxel
// is in work; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module volume_gradient_magnitude_core
   import vgm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_sample,
   input  logic                 req_volume_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]  rsp_grad_z,
   output logic [SAMPLE_W-1:0]  rsp_grad_y,
   output logic [SAMPLE_W-1:0]  rsp_grad_x,
   output logic [SAMPLE_W-1:0]  rsp_magnitude,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIFF   = 4'b0010,
      ST_SQUARE = 4'b0100,
      ST_ROOT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]    row_length_ff, rows_per_slice_ff;
   logic [COL_W-1:0]    col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]    row_pos_ff, row_pos_in;
   logic                past_slice_ff, past_slice_in;
   logic [SAMPLE_W-1:0] prev_voxel_ff;

   // voxel in work
   logic [SAMPLE_W-1:0] sample_ff;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                past_ff;
   logic                interior_ff;
   logic [SAMPLE_W-1:0] gz_ff, gy_ff, gx_ff;
   logic [1:0]          sq_cnt_ff, sq_cnt_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [SUM_W-1:0]    acc_ff;

   logic [SAMPLE_W-1:0] row_rd_ff, slice_rd_ff;
   logic [SAMPLE_W-1:0] row_mem   [MAX_ROW_LENGTH];
   logic [SAMPLE_W-1:0] slice_mem [SLICE_DEPTH];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_gz_ff, rsp_gy_ff, rsp_gx_ff, rsp_mag_ff;

   logic                accept, out_free, mem_we, load_out;
   logic [COL_W-1:0]    col_use;
   logic [ROW_W-1:0]    row_use;
   logic                past_use;
   logic [SLICE_AW-1:0] rd_addr, wr_addr;
   logic [LEN_W-1:0]    len_eff, rows_eff, col_next, row_next;
   logic [SAMPLE_W-1:0] sq_op;
   logic [SUM_W-1:0]    sum_final;
   logic                sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;
   logic [SAMPLE_W-1:0] mag_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // start mark clears the position before this voxel is used
   assign col_use  = req_volume_start ? '0 : col_pos_ff;
   assign row_use  = req_volume_start ? '0 : row_pos_ff;
   assign past_use = req_volume_start ? 1'b0 : past_slice_ff;
   assign rd_addr  = SLICE_AW'(row_use) * SLICE_AW'(MAX_ROW_LENGTH) + SLICE_AW'(col_use);
   assign wr_addr  = SLICE_AW'(row_ff) * SLICE_AW'(MAX_ROW_LENGTH) + SLICE_AW'(col_ff);

   assign len_eff  = clamp_len(row_length_ff, LEN_W'(MAX_ROW_LENGTH));
   assign rows_eff = clamp_len(rows_per_slice_ff, LEN_W'(MAX_ROWS));
   assign col_next = LEN_W'(col_ff) + LEN_W'(1);
   assign row_next = LEN_W'(row_ff) + LEN_W'(1);

   assign mem_we = (state_ff == ST_DIFF);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff     <= LEN_RESET;
         rows_per_slice_ff <= LEN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROW_LENGTH:     row_length_ff     <= csr_wdata;
            CSR_ROWS_PER_SLICE: rows_per_slice_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stores: read on transfer, write back during the difference cycle
   always_ff @(posedge clock) begin
      if (mem_we) row_mem[col_ff] <= sample_ff;
      if (accept) row_rd_ff <= row_mem[col_use];
   end

   always_ff @(posedge clock) begin
      if (mem_we) slice_mem[wr_addr] <= sample_ff;
      if (accept) slice_rd_ff <= slice_mem[rd_addr];
   end

   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    sq_op = gz_ff;
         2'd1:    sq_op = gy_ff;
         2'd2:    sq_op = gx_ff;
         default: sq_op = '0;
      endcase
   end

   assign sum_final  = interior_ff ? (acc_ff + SUM_W'(prod_ff)) : '0;
   assign sqrt_start = (state_ff == ST_SQUARE) && (sq_cnt_ff == 2'd3);
   assign load_out   = (state_ff == ST_ROOT) && sqrt_done && out_free;
   assign mag_sat    = (sqrt_root > ROOT_W'({SAMPLE_W{1'b1}})) ? {SAMPLE_W{1'b1}}
                                                                : sqrt_root[SAMPLE_W-1:0];

   always_comb begin
      state_in      = state_ff;
      sq_cnt_in     = sq_cnt_ff;
      col_pos_in    = col_pos_ff;
      row_pos_in    = row_pos_ff;
      past_slice_in = past_slice_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            sq_cnt_in = 2'd0;
            state_in  = ST_SQUARE;
            if (col_next >= len_eff) begin
               col_pos_in = '0;
               if (row_next >= rows_eff) begin
                  row_pos_in    = '0;
                  past_slice_in = 1'b1;
               end else begin
                  row_pos_in    = row_next[ROW_W-1:0];
                  past_slice_in = past_ff;
               end
            end else begin
               col_pos_in    = col_next[COL_W-1:0];
               row_pos_in    = row_ff;
               past_slice_in = past_ff;
            end
         end
         ST_SQUARE: begin
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sqrt_start) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sq_cnt_ff     <= '0;
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         past_slice_ff <= 1'b0;
         prev_voxel_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sq_cnt_ff     <= sq_cnt_in;
         col_pos_ff    <= col_pos_in;
         row_pos_ff    <= row_pos_in;
         past_slice_ff <= past_slice_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (mem_we) prev_voxel_ff <= sample_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         col_ff    <= col_use;
         row_ff    <= row_use;
         past_ff   <= past_use;
      end
      if (state_ff == ST_DIFF) begin
         gx_ff       <= (col_ff != '0) ? abs_diff(sample_ff, prev_voxel_ff) : '0;
         gy_ff       <= (row_ff != '0) ? abs_diff(sample_ff, row_rd_ff) : '0;
         gz_ff       <= past_ff ? abs_diff(sample_ff, slice_rd_ff) : '0;
         interior_ff <= (col_ff != '0) && (row_ff != '0) && past_ff;
      end
      if (state_ff == ST_SQUARE) begin
         prod_ff <= PROD_W'(sq_op) * PROD_W'(sq_op);
         acc_ff  <= (sq_cnt_ff == 2'd0) ? '0 : acc_ff + SUM_W'(prod_ff);
      end
      if (load_out) begin
         rsp_gz_ff  <= gz_ff;
         rsp_gy_ff  <= gy_ff;
         rsp_gx_ff  <= gx_ff;
         rsp_mag_ff <= mag_sat;
      end
   end

   vgm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_final),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_grad_z    = rsp_gz_ff;
   assign rsp_grad_y    = rsp_gy_ff;
   assign rsp_grad_x    = rsp_gx_ff;
   assign rsp_magnitude = rsp_mag_ff;

   // difference cycle only ever follows a voxel transfer
   a_diff_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> $past(req_valid && req_ready))
      else $error("difference cycle without a voxel transfer");

   // root of a sum of squares never exceeds the sum of the terms
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (18'(rsp_magnitude) <=
                        18'(rsp_grad_x) + 18'(rsp_grad_y) + 18'(rsp_grad_z)))
      else $error("magnitude above sum of gradients");

   // finished root moves into a free output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && sqrt_done && out_free) |=> (rsp_valid_ff && req_ready))
      else $error("finished result not presented");

endmodule
